// ===== rtl/pbe_pkg.sv =====
// package: constants, payload types, sine table and helpers of the particle burst engine
`default_nettype none
package pbe_pkg;

  localparam int CAPACITY     = 64;
  localparam int SINE_ENTRIES = 1024;

  localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CTR_W  = $clog2(CAPACITY + 1);
  localparam int ANG_W  = $clog2(SINE_ENTRIES);
  localparam int QTR    = SINE_ENTRIES / 4;
  localparam int QIDX_W = ANG_W - 1;

  localparam int CMD_W   = 2;
  localparam int TIME_W  = 16;
  localparam int POS_W   = 24;
  localparam int COL_W   = 24;
  localparam int TALLY_W = 7;
  localparam int PIX_W   = 16;
  localparam int ALPHA_W = 8;
  localparam int ACC_W   = 20;
  localparam int MAG_W   = 17;

  localparam int DIV_N_W   = 24;
  localparam int DIV_D_W   = 16;
  localparam int DIV_CNT_W = $clog2(DIV_N_W);

  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;

  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_BURST = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

  localparam logic [CMD_W-1:0] KIND_TICK  = 2'd0;
  localparam logic [CMD_W-1:0] KIND_BURST = 2'd1;
  localparam logic [CMD_W-1:0] KIND_READ  = 2'd2;

  localparam logic [1:0] REG_GRAVITY = 2'd0;
  localparam logic [1:0] REG_SPEED   = 2'd1;
  localparam logic [1:0] REG_LIFE    = 2'd2;

  localparam logic [ACC_W-1:0]  GRAVITY_RST = 20'd76800;
  localparam logic [ACC_W-1:0]  SPEED_RST   = 20'd30720;
  localparam logic [TIME_W-1:0] LIFE_RST    = 16'd52429;

  localparam logic signed [41:0] POS_MAX = 42'sd8388607;
  localparam logic signed [41:0] POS_MIN = -42'sd8388608;

  typedef struct packed {
    logic [CMD_W-1:0]        command;
    logic [TIME_W-1:0]       time_step;
    logic signed [POS_W-1:0] origin_x;
    logic signed [POS_W-1:0] origin_y;
    logic [TALLY_W-1:0]      burst_count;
    logic [COL_W-1:0]        burst_colour;
  } cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0]        kind;
    logic [TALLY_W-1:0]      tally;
    logic                    valid_res;
    logic signed [PIX_W-1:0] pixel_x;
    logic signed [PIX_W-1:0] pixel_y;
    logic [COL_W-1:0]        colour_out;
    logic [ALPHA_W-1:0]      alpha;
    logic                    last;
  } res_t;

  typedef struct packed {
    logic signed [POS_W-1:0] px;
    logic signed [POS_W-1:0] py;
    logic signed [POS_W-1:0] vx;
    logic signed [POS_W-1:0] vy;
    logic [TIME_W-1:0]       life;
    logic [TIME_W-1:0]       full;
    logic [COL_W-1:0]        col;
  } ent_t;

  typedef struct packed {
    logic               start;
    logic [DIV_N_W-1:0] dividend;
    logic [DIV_D_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [DIV_N_W-1:0] quotient;
  } div_rsp_t;

  typedef logic [MAG_W-1:0] sine_tab_t [0:QTR];

  // first quadrant of the sine, q15, degree-9 taylor in q30
  function automatic sine_tab_t build_sine();
    sine_tab_t tab;
    longint unsigned r, t, t2, a, s, q;
    for (int j = 0; j <= QTR; j++) begin
      r  = (longint'(j) << 32) / SINE_ENTRIES;
      t  = (r * 64'd1686629713) >> 30;
      t2 = (t * t) >> 30;
      a  = (64'd1 << 30) - t2 / 72;
      a  = (64'd1 << 30) - ((t2 * a) >> 30) / 42;
      a  = (64'd1 << 30) - ((t2 * a) >> 30) / 20;
      a  = (64'd1 << 30) - ((t2 * a) >> 30) / 6;
      s  = (t * a) >> 30;
      q  = (s + 64'd16384) >> 15;
      if (q > 64'd32768) q = 64'd32768;
      tab[j] = MAG_W'(q);
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine();

  // full-circle lookup by quadrant folding
  function automatic logic signed [MAG_W:0] sine_lut(logic [ANG_W-1:0] k);
    logic [1:0]        quad;
    logic [QIDX_W-1:0] j;
    logic [QIDX_W-1:0] ix;
    logic [MAG_W-1:0]  mag;
    quad = k[ANG_W-1 -: 2];
    j    = QIDX_W'(k[ANG_W-3:0]);
    ix   = quad[0] ? (QIDX_W'(QTR) - j) : j;
    mag  = SINE_TAB[ix];
    return quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  endfunction

  function automatic logic signed [POS_W-1:0] sat24(logic signed [41:0] v);
    if (v > POS_MAX) return POS_W'(POS_MAX);
    if (v < POS_MIN) return POS_W'(POS_MIN);
    return POS_W'(v);
  endfunction

endpackage
`default_nettype wire

// ===== rtl/pbe_cmd_if.sv =====
// interface: command channel with valid/ready handshake
`default_nettype none
interface pbe_cmd_if;
  logic          valid;
  logic          ready;
  pbe_pkg::cmd_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/pbe_res_if.sv =====
// interface: result channel with valid/ready handshake
`default_nettype none
interface pbe_res_if;
  logic          valid;
  logic          ready;
  pbe_pkg::res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/pbe_ram.sv =====
// generic single-port-write, single-port-read ram with registered read
`default_nettype none
module pbe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                              clk_i,
  input  wire logic                              we_i,
  input  wire logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                  wdata_i,
  input  wire logic                              re_i,
  input  wire logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                  rdata_o
);
  logic [WIDTH-1:0] mem_q [0:DEPTH-1];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule
`default_nettype wire

// ===== rtl/pbe_div.sv =====
// restoring divider, one quotient bit per cycle
`default_nettype none
module pbe_div (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire pbe_pkg::div_req_t req_i,
  output pbe_pkg::div_rsp_t      rsp_o
);
  logic                             busy_q, done_q;
  logic [pbe_pkg::DIV_CNT_W-1:0]    cnt_q;
  logic [pbe_pkg::DIV_D_W-1:0]      rem_q, dsr_q;
  logic [pbe_pkg::DIV_N_W-1:0]      quo_q;
  logic [pbe_pkg::DIV_D_W:0]        shifted;
  logic                             fits;

  // zero divisor gives an all-ones quotient
  assign shifted = {rem_q, quo_q[pbe_pkg::DIV_N_W-1]};
  assign fits    = shifted >= {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == pbe_pkg::DIV_CNT_W'(pbe_pkg::DIV_N_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.dividend;
      dsr_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= fits ? pbe_pkg::DIV_D_W'(shifted - {1'b0, dsr_q})
                    : pbe_pkg::DIV_D_W'(shifted);
      quo_q <= {quo_q[pbe_pkg::DIV_N_W-2:0], fits};
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;
endmodule
`default_nettype wire

// ===== rtl/particle_burst_engine.sv =====
// top level: particle store with tick, burst and readout sequencer
// tick: skips free slots; live slots read, multiplied, written back; end check and report
// burst: skips occupied slots; each spawned particle waits on the shared divider
// readout: skips free slots; each live slot waits on the divider for the alpha
// one command at a time; results leave through an output register, so a stall only holds push
// reset: control and config registers to defaults, live flags all cleared, no clearing pass
`default_nettype none
module particle_burst_engine (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  pbe_cmd_if.sink                               cmd_i,
  pbe_res_if.source                             res_o,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [pbe_pkg::APB_ADDR_W-1:0]   paddr,
  input  wire logic [pbe_pkg::APB_DATA_W-1:0]   pwdata,
  output logic      [pbe_pkg::APB_DATA_W-1:0]   prdata,
  output logic                                  pready
);

  typedef enum logic [15:0] {
    ST_IDLE   = 16'h0001,
    ST_T_RD   = 16'h0002,
    ST_T_MUL1 = 16'h0004,
    ST_T_MUL2 = 16'h0008,
    ST_T_WR   = 16'h0010,
    ST_B_SCAN = 16'h0020,
    ST_B_DIV  = 16'h0040,
    ST_B_SIN  = 16'h0080,
    ST_B_MUL  = 16'h0100,
    ST_B_WR   = 16'h0200,
    ST_R_RD   = 16'h0400,
    ST_R_DST  = 16'h0800,
    ST_R_DWT  = 16'h1000,
    ST_R_EMIT = 16'h2000,
    ST_R_END  = 16'h4000,
    ST_RPT    = 16'h8000
  } state_e;

  // configuration registers
  logic [pbe_pkg::ACC_W-1:0]  gravity_q, speed_q;
  logic [pbe_pkg::TIME_W-1:0] life_cfg_q;
  logic                       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gravity_q  <= pbe_pkg::GRAVITY_RST;
      speed_q    <= pbe_pkg::SPEED_RST;
      life_cfg_q <= pbe_pkg::LIFE_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        pbe_pkg::REG_GRAVITY: gravity_q  <= pwdata[pbe_pkg::ACC_W-1:0];
        pbe_pkg::REG_SPEED:   speed_q    <= pwdata[pbe_pkg::ACC_W-1:0];
        pbe_pkg::REG_LIFE:    life_cfg_q <= pwdata[pbe_pkg::TIME_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      pbe_pkg::REG_GRAVITY: prdata = pbe_pkg::APB_DATA_W'(gravity_q);
      pbe_pkg::REG_SPEED:   prdata = pbe_pkg::APB_DATA_W'(speed_q);
      pbe_pkg::REG_LIFE:    prdata = pbe_pkg::APB_DATA_W'(life_cfg_q);
      default:              prdata = '0;
    endcase
  end

  // control state
  state_e                        state_q, state_d;
  logic [pbe_pkg::CTR_W-1:0]     idx_q, idx_d;
  logic [pbe_pkg::TALLY_W-1:0]   n_q, n_d;
  logic                          pend_v_q, pend_v_d;
  logic                          out_v_q, out_v_d;
  logic [pbe_pkg::CAPACITY-1:0]  live_q;

  // payload registers
  pbe_pkg::cmd_t                 cmd_q;
  logic [pbe_pkg::ACC_W-1:0]     gdv_q;
  logic [pbe_pkg::CMD_W-1:0]     rpt_kind_q, rpt_kind_d;
  logic signed [pbe_pkg::POS_W-1:0] vy_q, pxn_q;
  logic signed [40:0]            prodx_q, prody_q;
  logic signed [pbe_pkg::MAG_W:0] sn_q, cs_q;
  logic [pbe_pkg::ANG_W-1:0]     ang_q;
  pbe_pkg::res_t                 cand_q, pend_q, out_q;

  // slot store
  pbe_pkg::ent_t                 rd_ent, wr_ent;
  logic                          ram_we, ram_re;
  logic [pbe_pkg::IDX_W-1:0]     slot;

  // divider
  pbe_pkg::div_req_t             div_req;
  pbe_pkg::div_rsp_t             div_rsp;

  logic                          accept, at_end, slot_live, can_push, push;
  logic                          live_we, live_val;
  pbe_pkg::res_t                 push_data;
  logic signed [16:0]            dts;
  logic [pbe_pkg::TIME_W-1:0]    life_n;

  assign slot      = idx_q[pbe_pkg::IDX_W-1:0];
  assign at_end    = idx_q == pbe_pkg::CTR_W'(pbe_pkg::CAPACITY);
  assign slot_live = live_q[slot];
  assign accept    = cmd_i.valid && cmd_i.ready;
  assign can_push  = !out_v_q || res_o.ready;
  assign dts       = $signed({1'b0, cmd_q.time_step});
  assign life_n    = (rd_ent.life > cmd_q.time_step) ? rd_ent.life - cmd_q.time_step : '0;

  assign cmd_i.ready = state_q == ST_IDLE;
  assign res_o.valid = out_v_q;
  assign res_o.data  = out_q;

  pbe_ram #(
    .WIDTH ($bits(pbe_pkg::ent_t)),
    .DEPTH (pbe_pkg::CAPACITY)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (slot),
    .wdata_i (wr_ent),
    .re_i    (ram_re),
    .raddr_i (slot),
    .rdata_o (rd_ent)
  );

  pbe_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // truncate toward zero to whole pixels
  function automatic logic signed [pbe_pkg::PIX_W-1:0] to_pixel(
    logic signed [pbe_pkg::POS_W-1:0] p);
    logic signed [pbe_pkg::POS_W:0] t;
    t = (pbe_pkg::POS_W+1)'(p) + (p[pbe_pkg::POS_W-1] ? 25'sd255 : 25'sd0);
    return pbe_pkg::PIX_W'(t >>> 8);
  endfunction

  // sequencer
  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    n_d        = n_q;
    pend_v_d   = pend_v_q;
    rpt_kind_d = rpt_kind_q;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    live_we    = 1'b0;
    live_val   = 1'b0;
    push       = 1'b0;
    push_data  = '0;
    div_req    = '0;
    wr_ent     = rd_ent;

    case (state_q)
      ST_IDLE: begin
        if (cmd_i.valid) begin
          idx_d = '0;
          n_d   = '0;
          case (cmd_i.data.command)
            pbe_pkg::CMD_TICK:  state_d = ST_T_RD;
            pbe_pkg::CMD_BURST: state_d = ST_B_SCAN;
            pbe_pkg::CMD_READ: begin
              state_d  = ST_R_RD;
              pend_v_d = 1'b0;
            end
            default: ; // unused command, dropped
          endcase
        end
      end

      // tick: read, gravity + x product, y product, write back
      ST_T_RD: begin
        if (at_end) begin
          rpt_kind_d = pbe_pkg::KIND_TICK;
          state_d    = ST_RPT;
        end else if (slot_live) begin
          ram_re  = 1'b1;
          state_d = ST_T_MUL1;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_T_MUL1: state_d = ST_T_MUL2;
      ST_T_MUL2: state_d = ST_T_WR;
      ST_T_WR: begin
        wr_ent.px   = pxn_q;
        wr_ent.py   = pbe_pkg::sat24(42'(rd_ent.py) + 42'(prody_q >>> 16));
        wr_ent.vy   = vy_q;
        wr_ent.life = life_n;
        ram_we      = 1'b1;
        live_we     = 1'b1;
        live_val    = life_n != '0;
        if (life_n != '0) n_d = n_q + 1'b1;
        idx_d   = idx_q + 1'b1;
        state_d = ST_T_RD;
      end

      // burst: find free slot, divide for the angle, look up, scale, write
      ST_B_SCAN: begin
        if (at_end || n_q >= cmd_q.burst_count) begin
          rpt_kind_d = pbe_pkg::KIND_BURST;
          state_d    = ST_RPT;
        end else if (slot_live) begin
          idx_d = idx_q + 1'b1;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = pbe_pkg::DIV_N_W'({n_q, {pbe_pkg::ANG_W{1'b0}}});
          div_req.divisor  = pbe_pkg::DIV_D_W'(cmd_q.burst_count);
          state_d          = ST_B_DIV;
        end
      end
      ST_B_DIV: if (div_rsp.done) state_d = ST_B_SIN;
      ST_B_SIN: state_d = ST_B_MUL;
      ST_B_MUL: state_d = ST_B_WR;
      ST_B_WR: begin
        wr_ent.px   = cmd_q.origin_x;
        wr_ent.py   = cmd_q.origin_y;
        wr_ent.vx   = pbe_pkg::sat24(42'(prodx_q >>> 15));
        wr_ent.vy   = pbe_pkg::sat24(42'(prody_q >>> 15));
        wr_ent.life = life_cfg_q;
        wr_ent.full = life_cfg_q;
        wr_ent.col  = cmd_q.burst_colour;
        ram_we      = 1'b1;
        live_we     = 1'b1;
        live_val    = life_cfg_q != '0;
        n_d         = n_q + 1'b1;
        idx_d       = idx_q + 1'b1;
        state_d     = ST_B_SCAN;
      end

      // readout: one result held back so the final one can carry last
      ST_R_RD: begin
        if (at_end) begin
          state_d = ST_R_END;
        end else if (slot_live) begin
          ram_re  = 1'b1;
          state_d = ST_R_DST;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_R_DST: begin
        div_req.start    = 1'b1;
        div_req.dividend = pbe_pkg::DIV_N_W'({rd_ent.life, 8'd0})
                         - pbe_pkg::DIV_N_W'(rd_ent.life);
        div_req.divisor  = rd_ent.full;
        state_d          = ST_R_DWT;
      end
      ST_R_DWT: if (div_rsp.done) state_d = ST_R_EMIT;
      ST_R_EMIT: begin
        if (!pend_v_q) begin
          pend_v_d = 1'b1;
          idx_d    = idx_q + 1'b1;
          state_d  = ST_R_RD;
        end else if (can_push) begin
          push      = 1'b1;
          push_data = pend_q;
          idx_d     = idx_q + 1'b1;
          state_d   = ST_R_RD;
        end
      end
      ST_R_END: begin
        if (can_push) begin
          push = 1'b1;
          if (pend_v_q) begin
            push_data = pend_q;
          end else begin
            push_data.kind = pbe_pkg::KIND_READ;
          end
          push_data.last = 1'b1;
          pend_v_d       = 1'b0;
          state_d        = ST_IDLE;
        end
      end

      ST_RPT: begin
        if (can_push) begin
          push            = 1'b1;
          push_data.kind  = rpt_kind_q;
          push_data.tally = n_q;
          push_data.last  = 1'b1;
          state_d         = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_v_d = out_v_q;
    if (push) begin
      out_v_d = 1'b1;
    end else if (res_o.ready) begin
      out_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      idx_q    <= '0;
      n_q      <= '0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
      live_q   <= '0;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      n_q      <= n_d;
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
      if (live_we) live_q[slot] <= live_val;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    rpt_kind_q <= rpt_kind_d;
    if (accept) begin
      cmd_q <= cmd_i.data;
      gdv_q <= pbe_pkg::ACC_W'((36'(gravity_q) * 36'(cmd_i.data.time_step)) >> 16);
    end
    if (push) out_q <= push_data;
    case (state_q)
      ST_T_MUL1: begin
        vy_q    <= pbe_pkg::sat24(42'(rd_ent.vy) + 42'($signed({1'b0, gdv_q})));
        prodx_q <= rd_ent.vx * dts;
      end
      ST_T_MUL2: begin
        prody_q <= vy_q * dts;
        pxn_q   <= pbe_pkg::sat24(42'(rd_ent.px) + 42'(prodx_q >>> 16));
      end
      ST_B_DIV: ang_q <= div_rsp.quotient[pbe_pkg::ANG_W-1:0];
      ST_B_SIN: begin
        sn_q <= pbe_pkg::sine_lut(ang_q);
        cs_q <= pbe_pkg::sine_lut(ang_q + pbe_pkg::ANG_W'(pbe_pkg::QTR));
      end
      ST_B_MUL: begin
        prodx_q <= cs_q * $signed({1'b0, speed_q});
        prody_q <= sn_q * $signed({1'b0, speed_q});
      end
      ST_R_DST: begin
        cand_q <= '{kind:       pbe_pkg::KIND_READ,
                    tally:      '0,
                    valid_res:  1'b1,
                    pixel_x:    to_pixel(rd_ent.px),
                    pixel_y:    to_pixel(rd_ent.py),
                    colour_out: rd_ent.col,
                    alpha:      '0,
                    last:       1'b0};
      end
      ST_R_DWT: begin
        if (div_rsp.done) begin
          cand_q.alpha <= (div_rsp.quotient > pbe_pkg::DIV_N_W'(255)) ? 8'd255
                        : div_rsp.quotient[pbe_pkg::ALPHA_W-1:0];
        end
      end
      ST_R_EMIT: begin
        if (!pend_v_q || can_push) pend_q <= cand_q;
      end
      default: ;
    endcase
  end

  // checks
  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> !ram_re)
    else $error("store read and write in the same cycle");

  a_tally_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_q.kind != pbe_pkg::KIND_READ)
      |-> out_q.tally <= pbe_pkg::TALLY_W'(pbe_pkg::CAPACITY))
    else $error("report tally beyond capacity");

  a_empty_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_q.kind == pbe_pkg::KIND_READ && !out_q.valid_res) |-> out_q.last)
    else $error("empty readout without last");

  a_burst_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_B_WR && life_cfg_q != '0) |=> live_q[$past(slot)])
    else $error("spawned slot not marked live");

  a_div_idle_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |=> !div_rsp.done)
    else $error("divider done right after start");

endmodule
`default_nettype wire

// ===== verif/particle_burst_engine_tb.sv =====
// testbench: particle burst engine checked against a cycle-free behavioral predictor
`default_nettype none
module particle_burst_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [pbe_pkg::APB_ADDR_W-1:0] paddr = '0;
  logic [pbe_pkg::APB_DATA_W-1:0] pwdata = '0;
  logic [pbe_pkg::APB_DATA_W-1:0] prdata;
  logic pready;

  pbe_cmd_if cmd_ch();
  pbe_res_if res_ch();

  particle_burst_engine dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cmd_i(cmd_ch.sink), .res_o(res_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk_i = ~clk_i;

  // predictor state, one copy per slot
  longint slot_px [pbe_pkg::CAPACITY];
  longint slot_py [pbe_pkg::CAPACITY];
  longint slot_vx [pbe_pkg::CAPACITY];
  longint slot_vy [pbe_pkg::CAPACITY];
  int unsigned slot_life [pbe_pkg::CAPACITY];
  int unsigned slot_full [pbe_pkg::CAPACITY];
  logic [pbe_pkg::COL_W-1:0] slot_col [pbe_pkg::CAPACITY];
  int unsigned grav_q = pbe_pkg::GRAVITY_RST;
  int unsigned speed_q = pbe_pkg::SPEED_RST;
  int unsigned life_q = pbe_pkg::LIFE_RST;

  pbe_pkg::res_t pending_results [$];
  int errors = 0;
  bit long_hold = 1'b0;
  bit quiet_gaps = 1'b0;

  // sender and receiver state
  initial begin
    cmd_ch.valid = 1'b0;
    cmd_ch.data = '0;
    res_ch.ready = 1'b0;
  end

  task automatic report_mismatch(input string what);
    errors++;
    $display("mismatch: %s", what);
  endtask

  function automatic longint floor_div(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint sat_pos(longint v);
    if (v > 8388607) return 8388607;
    if (v < -8388608) return -8388608;
    return v;
  endfunction

  // independent sine evaluation with quadrant folding
  function automatic longint sine_q15(int unsigned k);
    longint unsigned ph, r, t, t2, a, s, q;
    int unsigned quad;
    ph = (longint'(k % pbe_pkg::SINE_ENTRIES) << 32) / pbe_pkg::SINE_ENTRIES;
    quad = 32'((ph >> 30) & 64'd3);
    r = ph & ((64'd1 << 30) - 1);
    if (quad & 1) r = (64'd1 << 30) - r;
    t = (r * 64'd1686629713) >> 30;
    t2 = (t * t) >> 30;
    a = (64'd1 << 30) - t2 / 72;
    a = (64'd1 << 30) - ((t2 * a) >> 30) / 42;
    a = (64'd1 << 30) - ((t2 * a) >> 30) / 20;
    a = (64'd1 << 30) - ((t2 * a) >> 30) / 6;
    s = (t * a) >> 30;
    q = (s + 16384) >> 15;
    if (q > 32768) q = 32768;
    return (quad & 2) ? -longint'(q) : longint'(q);
  endfunction

  function automatic pbe_pkg::res_t blank_result(logic [pbe_pkg::CMD_W-1:0] k);
    pbe_pkg::res_t r;
    r = '0;
    r.kind = k;
    r.last = 1'b1;
    return r;
  endfunction

  // work out the results of one accepted command and update the model state
  task automatic predict_particles(input pbe_pkg::cmd_t c);
    int n;
    pbe_pkg::res_t r;
    longint vy, sn, cs, tr;
    int unsigned a, al, dt, cnt;
    n = 0;
    dt = c.time_step;
    case (c.command)
      pbe_pkg::CMD_TICK: begin
        for (int i = 0; i < pbe_pkg::CAPACITY; i++) begin
          if (slot_life[i] == 0) continue;
          vy = sat_pos(slot_vy[i] + longint'((longint'(grav_q) * dt) >> 16));
          slot_vy[i] = vy;
          slot_px[i] = sat_pos(slot_px[i] + floor_div(slot_vx[i] * dt, 16));
          slot_py[i] = sat_pos(slot_py[i] + floor_div(vy * dt, 16));
          slot_life[i] = (slot_life[i] > dt) ? slot_life[i] - dt : 0;
          if (slot_life[i] != 0) n++;
        end
        r = blank_result(pbe_pkg::KIND_TICK);
        r.tally = pbe_pkg::TALLY_W'(n);
        pending_results.push_back(r);
      end
      pbe_pkg::CMD_BURST: begin
        cnt = c.burst_count;
        for (int i = 0; i < pbe_pkg::CAPACITY && n < cnt; i++) begin
          if (slot_life[i] != 0) continue;
          a = 32'((longint'(n) * pbe_pkg::SINE_ENTRIES) / cnt);
          sn = sine_q15(a);
          cs = sine_q15((a + pbe_pkg::SINE_ENTRIES / 4) % pbe_pkg::SINE_ENTRIES);
          slot_px[i] = c.origin_x;
          slot_py[i] = c.origin_y;
          slot_vx[i] = sat_pos(floor_div(cs * speed_q, 15));
          slot_vy[i] = sat_pos(floor_div(sn * speed_q, 15));
          slot_life[i] = life_q;
          slot_full[i] = life_q;
          slot_col[i] = c.burst_colour;
          n++;
        end
        r = blank_result(pbe_pkg::KIND_BURST);
        r.tally = pbe_pkg::TALLY_W'(n);
        pending_results.push_back(r);
      end
      pbe_pkg::CMD_READ: begin
        for (int i = 0; i < pbe_pkg::CAPACITY; i++) begin
          if (slot_life[i] == 0) continue;
          if (slot_full[i] == 0) al = 255;
          else begin
            al = 32'((longint'(slot_life[i]) * 255) / slot_full[i]);
            if (al > 255) al = 255;
          end
          r = '0;
          r.kind = pbe_pkg::KIND_READ;
          r.valid_res = 1'b1;
          tr = (slot_px[i] < 0) ? -((-slot_px[i]) >> 8) : (slot_px[i] >> 8);
          r.pixel_x = pbe_pkg::PIX_W'(tr);
          tr = (slot_py[i] < 0) ? -((-slot_py[i]) >> 8) : (slot_py[i] >> 8);
          r.pixel_y = pbe_pkg::PIX_W'(tr);
          r.colour_out = slot_col[i];
          r.alpha = pbe_pkg::ALPHA_W'(al);
          pending_results.push_back(r);
          n++;
        end
        if (n == 0) pending_results.push_back(blank_result(pbe_pkg::KIND_READ));
        else pending_results[$].last = 1'b1;
      end
      default: ;
    endcase
  endtask

  // offer one command, idling in bursts, and predict once it is accepted
  int burst_left = 0;
  task automatic send_command(input pbe_pkg::cmd_t c);
    int gap;
    gap = 0;
    if (!quiet_gaps && burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      gap = $urandom_range(0, 6);
    end
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    if (burst_left > 0) burst_left--;
    cmd_ch.valid <= 1'b1;
    cmd_ch.data <= c;
    do @(posedge clk_i); while (!(cmd_ch.valid && cmd_ch.ready));
    predict_particles(c);
  endtask

  function automatic pbe_pkg::cmd_t make_cmd(logic [pbe_pkg::CMD_W-1:0] op);
    pbe_pkg::cmd_t c;
    c.command = op;
    c.time_step = pbe_pkg::TIME_W'($urandom_range(0, 65535));
    c.origin_x = pbe_pkg::POS_W'($urandom);
    c.origin_y = pbe_pkg::POS_W'($urandom);
    c.burst_count = pbe_pkg::TALLY_W'($urandom_range(0, 64));
    c.burst_colour = pbe_pkg::COL_W'($urandom);
    return c;
  endfunction

  // setup and access phase; the caller releases the bus after its last write
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0; paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      pbe_pkg::REG_GRAVITY: grav_q = val[pbe_pkg::ACC_W-1:0];
      pbe_pkg::REG_SPEED:   speed_q = val[pbe_pkg::ACC_W-1:0];
      pbe_pkg::REG_LIFE:    life_q = val[pbe_pkg::TIME_W-1:0];
      default: ;
    endcase
  endtask

  // wait for every expected transaction, then let the sequencer settle
  task automatic drain_results();
    cmd_ch.valid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (300) @(posedge clk_i);
  endtask

  task automatic set_registers(input int g, input int s, input int l);
    drain_results();
    write_reg(pbe_pkg::REG_GRAVITY, g);
    write_reg(pbe_pkg::REG_SPEED, s);
    write_reg(pbe_pkg::REG_LIFE, l);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // empty readout, zero bursts, overflow and extreme fields
  task automatic test_directed();
    pbe_pkg::cmd_t c;
    send_command(make_cmd(pbe_pkg::CMD_READ));
    c = make_cmd(pbe_pkg::CMD_TICK); c.time_step = 16'hFFFF; send_command(c);
    c = make_cmd(pbe_pkg::CMD_BURST); c.burst_count = '0; send_command(c);
    c = make_cmd(pbe_pkg::CMD_BURST); c.burst_count = 7'd1; c.origin_x = 24'sh7FFFFF;
    c.origin_y = -24'sh800000; c.burst_colour = 24'hFFFFFF; send_command(c);
    c = make_cmd(pbe_pkg::CMD_BURST); c.burst_count = 7'd64; c.origin_x = -24'sh800000;
    c.origin_y = 24'sh7FFFFF; c.burst_colour = '0; send_command(c);
    c = make_cmd(pbe_pkg::CMD_BURST); c.burst_count = 7'd127; send_command(c);
    send_command(make_cmd(pbe_pkg::CMD_READ));
    c = make_cmd(pbe_pkg::CMD_TICK); c.time_step = '0; send_command(c);
    c = make_cmd(pbe_pkg::CMD_TICK); c.time_step = 16'd1000; send_command(c);
    send_command(make_cmd(pbe_pkg::CMD_READ));
    c = make_cmd(2'd3); send_command(c);
    c = make_cmd(pbe_pkg::CMD_TICK); c.time_step = 16'hFFFF; send_command(c);
    send_command(make_cmd(pbe_pkg::CMD_READ));
  endtask

  // extreme register settings, zero lifetime among them
  task automatic test_register_extremes();
    pbe_pkg::cmd_t c;
    set_registers(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
    c = make_cmd(pbe_pkg::CMD_BURST); c.burst_count = 7'd5; send_command(c);
    c = make_cmd(pbe_pkg::CMD_TICK); c.time_step = 16'hFFFF; send_command(c);
    send_command(make_cmd(pbe_pkg::CMD_READ));
    set_registers(0, 0, 0);
    c = make_cmd(pbe_pkg::CMD_BURST); c.burst_count = 7'd9; send_command(c);
    send_command(make_cmd(pbe_pkg::CMD_READ));
    set_registers(1, 1, 1);
    c = make_cmd(pbe_pkg::CMD_BURST); c.burst_count = 7'd3; send_command(c);
    c = make_cmd(pbe_pkg::CMD_TICK); c.time_step = '0; send_command(c);
    send_command(make_cmd(pbe_pkg::CMD_READ));
    c = make_cmd(pbe_pkg::CMD_TICK); c.time_step = 16'd1; send_command(c);
  endtask

  // mostly bursts and ticks with readouts, under fresh register settings
  task automatic test_random_traffic(input int items);
    int p;
    pbe_pkg::cmd_t c;
    for (int i = 0; i < items; i++) begin
      if (i % 60 == 0)
        set_registers($urandom_range(0, 20'hFFFFF), $urandom_range(0, 20'hFFFFF),
                      $urandom_range(1, 65535));
      p = $urandom_range(0, 99);
      if (p < 35) begin
        c = make_cmd(pbe_pkg::CMD_BURST);
        if ($urandom_range(0, 3) != 0) c.burst_count = pbe_pkg::TALLY_W'($urandom_range(0, 20));
      end else if (p < 75) begin
        c = make_cmd(pbe_pkg::CMD_TICK);
        if ($urandom_range(0, 2) != 0) c.time_step = pbe_pkg::TIME_W'($urandom_range(0, 8000));
      end else if (p < 97) c = make_cmd(pbe_pkg::CMD_READ);
      else c = make_cmd(2'd3);
      send_command(c);
    end
  endtask

  // receiver holds off for a long time while commands keep coming
  task automatic test_back_pressure();
    pbe_pkg::cmd_t c;
    quiet_gaps = 1'b1;
    long_hold = 1'b1;
    for (int i = 0; i < 8; i++) begin
      c = make_cmd(i % 2 ? pbe_pkg::CMD_READ : pbe_pkg::CMD_BURST);
      c.burst_count = 7'd4;
      send_command(c);
    end
    quiet_gaps = 1'b0;
  endtask

  // receiver stall pattern and the long hold-off
  initial begin : receiver
    int hold;
    hold = 0;
    forever begin
      @(posedge clk_i);
      if (long_hold) begin
        res_ch.ready <= 1'b0;
        hold++;
        if (hold >= 2000) begin
          long_hold = 1'b0;
          hold = 0;
        end
      end else if ($urandom_range(0, 15) < 3) res_ch.ready <= 1'b0;
      else res_ch.ready <= ($urandom_range(0, 9) != 0);
    end
  end

  // compare each result transaction with the oldest expectation
  always @(posedge clk_i) begin
    pbe_pkg::res_t got, want;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      got = res_ch.data;
      if (pending_results.size() == 0) report_mismatch("result with nothing expected");
      else begin
        want = pending_results.pop_front();
        if (got.kind != want.kind) report_mismatch("kind");
        if (got.tally != want.tally) report_mismatch("tally");
        if (got.valid_res != want.valid_res) report_mismatch("valid_res");
        if (got.pixel_x != want.pixel_x) report_mismatch("pixel_x");
        if (got.pixel_y != want.pixel_y) report_mismatch("pixel_y");
        if (got.colour_out != want.colour_out) report_mismatch("colour_out");
        if (got.alpha != want.alpha) report_mismatch("alpha");
        if (got.last != want.last) report_mismatch("last");
      end
    end
  end

  initial begin
    for (int i = 0; i < pbe_pkg::CAPACITY; i++) begin
      slot_px[i] = 0; slot_py[i] = 0; slot_vx[i] = 0; slot_vy[i] = 0;
      slot_life[i] = 0; slot_full[i] = 0; slot_col[i] = '0;
    end
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_register_extremes();
    test_back_pressure();
    test_random_traffic(240);
    drain_results();
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  // generous ceiling on the whole run
  initial begin
    #20ms;
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule
`default_nettype wire
